FILE: src/ldrc_pkg.sv
// -----------------------------------------------------------------------------
// ldrc_pkg
// Shared widths and types for the linear Diophantine range counter.
// -----------------------------------------------------------------------------
package ldrc_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int NUM_W         = 66;  // wide signed datapath, dividend width
  localparam int DEN_W         = 34;  // signed divisor and remainder width
  localparam int MUL_W         = 35;  // signed multiplier operand width
  localparam int PROD_W        = 2 * MUL_W;
  localparam int COUNT_W       = 64;
  localparam int DIV_CNT_W     = $clog2(NUM_W + 1);

  typedef logic signed [NUM_W-1:0]  wide_t;
  typedef logic signed [DEN_W-1:0]  den_t;
  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

FILE: src/linear_diophantine_range_count_top.sv
// -----------------------------------------------------------------------------
// linear_diophantine_range_count_top
// Counts integer pairs (x, y) on a*x + b*y = c inside inclusive x and y bounds.
// -----------------------------------------------------------------------------
// channel   | handshake            | words
// ----------+----------------------+------------------------------------------
// query in  | start_i / busy_o     | coef_a_i coef_b_i rhs_c_i x_/y_ low/high
// count out | done_o (1-cycle)     | solution_count_o
//
// A query runs its divisions one after another on the shared serial divider,
// one division per extended Euclid step (with the multiply and update), then
// the remaining divisions for the solution and its bounds. Empty ranges and
// both coefficients zero skip the divider; a single zero coefficient needs
// only one division.
// Busy stays high from acceptance until the count strobe. Reset clears only
// control state. The receiver cannot stall: each count is shown for one cycle.
// -----------------------------------------------------------------------------
module linear_diophantine_range_count_top import ldrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [31:0]           coef_a_i,
  input  logic [31:0]           coef_b_i,
  input  logic [31:0]           rhs_c_i,
  input  logic [31:0]           x_low_i,
  input  logic [31:0]           x_high_i,
  input  logic [31:0]           y_low_i,
  input  logic [31:0]           y_high_i,
  output logic                  done_o,
  output logic [COUNT_W-1:0]    solution_count_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_WAIT, S_ZZ_MUL, S_ZZ_OUT, S_AZ_CHK, S_BZ_CHK,
    S_G_TEST, S_G_MUL, S_G_UPD, S_CG_CHK, S_BP_GET, S_AG_GET, S_SA_GET,
    S_CM_GET, S_X0_MUL, S_X0_DIV, S_X0_GET, S_Y0_MUL, S_Y0_DIV, S_Y0_GET,
    S_K1, S_K2, S_K3, S_K4, S_FIN
  } state_e;

  state_e state_q, ret_q;
  logic   done_q;
  logic [COUNT_W-1:0] count_q;

  wide_t a_q, b_q, c_q, xl_q, xh_q, yl_q, yh_q;
  wide_t r0_q, r1_q, s0_q, s1_q, cg_q, bp_q, ag_q, sa_q, cm_q;
  wide_t x0_q, y0_q, ap_q, klo_q, khi_q;
  prod_t prod_q;

  logic  div_start, div_busy;
  wide_t div_num, div_quo;
  den_t  div_den, div_rem;
  mul_t  mul_x, mul_y;
  logic  mul_en;

  wide_t wx, wy, b_abs, an, rem_w, prod_w, q_ceil, q_floor;
  logic  empty, a_zero, b_zero, rem_neg, rem_pos;

  assign wx      = xh_q - xl_q + wide_t'(1);
  assign wy      = yh_q - yl_q + wide_t'(1);
  assign empty   = (xl_q > xh_q) || (yl_q > yh_q);
  assign a_zero  = a_q == '0;
  assign b_zero  = b_q == '0;
  assign b_abs   = b_q[NUM_W-1] ? -b_q : b_q;
  assign an      = ap_q[NUM_W-1] ? -ap_q : ap_q;
  assign rem_w   = wide_t'(div_rem);
  assign prod_w  = prod_q[NUM_W-1:0];
  assign rem_neg = div_rem[DEN_W-1];
  assign rem_pos = !rem_neg && (div_rem != '0);
  assign q_ceil  = div_quo + wide_t'({1'b0, rem_pos});
  assign q_floor = div_quo - wide_t'({1'b0, rem_neg});

  ldrc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // divider and multiplier operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_en    = 1'b0;
    mul_x     = '0;
    mul_y     = '0;
    case (state_q)
      S_CHK: begin
        div_num = c_q;
        if (a_zero) begin
          div_den = den_t'(b_q);
        end else begin
          div_den = den_t'(a_q);
        end
        div_start = !empty && (a_zero != b_zero);
      end
      S_G_TEST: begin
        div_start = 1'b1;
        if (r1_q == '0) begin
          div_num = c_q;
          div_den = den_t'(r0_q);
        end else begin
          div_num = r0_q;
          div_den = den_t'(r1_q);
        end
      end
      S_CG_CHK: begin
        div_start = div_rem == '0;
        div_num   = b_abs;
        div_den   = den_t'(r0_q);
      end
      S_BP_GET: begin
        div_start = 1'b1;
        div_num   = a_q;
        div_den   = den_t'(r0_q);
      end
      S_AG_GET: begin
        div_start = 1'b1;
        div_num   = a_q[NUM_W-1] ? -s0_q : s0_q;
        div_den   = den_t'(bp_q);
      end
      S_SA_GET: begin
        div_start = 1'b1;
        div_num   = cg_q;
        div_den   = den_t'(bp_q);
      end
      S_X0_DIV: begin
        div_start = 1'b1;
        div_num   = prod_w;
        div_den   = den_t'(bp_q);
      end
      S_Y0_DIV: begin
        div_start = 1'b1;
        div_num   = c_q - prod_w;
        div_den   = den_t'(b_q);
      end
      S_Y0_GET: begin
        div_start = 1'b1;
        div_num   = xl_q - x0_q;
        div_den   = den_t'(bp_q);
      end
      S_K1: begin
        div_start = 1'b1;
        div_num   = xh_q - x0_q;
        div_den   = den_t'(bp_q);
      end
      S_K2: begin
        div_start = 1'b1;
        div_num   = ap_q[NUM_W-1] ? yl_q - y0_q : y0_q - yh_q;
        div_den   = den_t'(an);
      end
      S_K3: begin
        div_start = 1'b1;
        div_num   = ap_q[NUM_W-1] ? yh_q - y0_q : y0_q - yl_q;
        div_den   = den_t'(an);
      end
      S_ZZ_MUL: begin
        mul_en = 1'b1;
        mul_x  = mul_t'(wx);
        mul_y  = mul_t'(wy);
      end
      S_G_MUL: begin
        mul_en = 1'b1;
        mul_x  = mul_t'(div_quo);
        mul_y  = mul_t'(s1_q);
      end
      S_X0_MUL: begin
        mul_en = 1'b1;
        mul_x  = mul_t'(sa_q);
        mul_y  = mul_t'(cm_q);
      end
      S_Y0_MUL: begin
        mul_en = 1'b1;
        mul_x  = mul_t'(a_q);
        mul_y  = mul_t'(x0_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (mul_en) begin
        prod_q <= mul_x * mul_y;
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            a_q     <= wide_t'($signed(coef_a_i[OPERAND_WIDTH-1:0]));
            b_q     <= wide_t'($signed(coef_b_i[OPERAND_WIDTH-1:0]));
            c_q     <= wide_t'($signed(rhs_c_i[OPERAND_WIDTH-1:0]));
            xl_q    <= wide_t'($signed(x_low_i[OPERAND_WIDTH-1:0]));
            xh_q    <= wide_t'($signed(x_high_i[OPERAND_WIDTH-1:0]));
            yl_q    <= wide_t'($signed(y_low_i[OPERAND_WIDTH-1:0]));
            yh_q    <= wide_t'($signed(y_high_i[OPERAND_WIDTH-1:0]));
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (empty || (a_zero && b_zero && c_q != '0)) begin
            count_q <= '0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (a_zero && b_zero) begin
            state_q <= S_ZZ_MUL;
          end else if (a_zero) begin
            ret_q   <= S_AZ_CHK;
            state_q <= S_WAIT;
          end else if (b_zero) begin
            ret_q   <= S_BZ_CHK;
            state_q <= S_WAIT;
          end else begin
            r0_q    <= a_q[NUM_W-1] ? -a_q : a_q;
            r1_q    <= b_abs;
            s0_q    <= wide_t'(1);
            s1_q    <= '0;
            state_q <= S_G_TEST;
          end
        end
        S_WAIT: begin
          if (!div_busy) begin
            state_q <= ret_q;
          end
        end
        S_ZZ_MUL: begin
          state_q <= S_ZZ_OUT;
        end
        S_ZZ_OUT: begin
          // saturate anything past 64 bits
          count_q <= (prod_q[PROD_W-1:COUNT_W] != '0) ? '1 : prod_q[COUNT_W-1:0];
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_AZ_CHK: begin
          count_q <= (div_rem == '0 && div_quo >= yl_q && div_quo <= yh_q)
                     ? wx[COUNT_W-1:0] : '0;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_BZ_CHK: begin
          count_q <= (div_rem == '0 && div_quo >= xl_q && div_quo <= xh_q)
                     ? wy[COUNT_W-1:0] : '0;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_G_TEST: begin
          // r1 reached zero: r0 is the gcd, go test c against it
          ret_q   <= (r1_q == '0) ? S_CG_CHK : S_G_MUL;
          state_q <= S_WAIT;
        end
        S_G_MUL: begin
          state_q <= S_G_UPD;
        end
        S_G_UPD: begin
          r0_q    <= r1_q;
          r1_q    <= rem_w;
          s0_q    <= s1_q;
          s1_q    <= s0_q - prod_w;
          state_q <= S_G_TEST;
        end
        S_CG_CHK: begin
          if (div_rem != '0) begin
            count_q <= '0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            cg_q    <= div_quo;
            ret_q   <= S_BP_GET;
            state_q <= S_WAIT;
          end
        end
        S_BP_GET: begin
          bp_q    <= div_quo;
          ret_q   <= S_AG_GET;
          state_q <= S_WAIT;
        end
        S_AG_GET: begin
          ag_q    <= div_quo;
          ret_q   <= S_SA_GET;
          state_q <= S_WAIT;
        end
        S_SA_GET: begin
          sa_q    <= rem_neg ? rem_w + bp_q : rem_w;
          ret_q   <= S_CM_GET;
          state_q <= S_WAIT;
        end
        S_CM_GET: begin
          cm_q    <= rem_neg ? rem_w + bp_q : rem_w;
          state_q <= S_X0_MUL;
        end
        S_X0_MUL: begin
          state_q <= S_X0_DIV;
        end
        S_X0_DIV: begin
          ret_q   <= S_X0_GET;
          state_q <= S_WAIT;
        end
        S_X0_GET: begin
          x0_q    <= rem_w;
          state_q <= S_Y0_MUL;
        end
        S_Y0_MUL: begin
          state_q <= S_Y0_DIV;
        end
        S_Y0_DIV: begin
          ret_q   <= S_Y0_GET;
          state_q <= S_WAIT;
        end
        S_Y0_GET: begin
          y0_q    <= div_quo;
          // negated step of y along the solution line, oriented so x steps by +bp
          ap_q    <= b_q[NUM_W-1] ? -ag_q : ag_q;
          ret_q   <= S_K1;
          state_q <= S_WAIT;
        end
        S_K1: begin
          klo_q   <= q_ceil;
          ret_q   <= S_K2;
          state_q <= S_WAIT;
        end
        S_K2: begin
          khi_q   <= q_floor;
          ret_q   <= S_K3;
          state_q <= S_WAIT;
        end
        S_K3: begin
          if (q_ceil > klo_q) begin
            klo_q <= q_ceil;
          end
          ret_q   <= S_K4;
          state_q <= S_WAIT;
        end
        S_K4: begin
          if (q_floor < khi_q) begin
            khi_q <= q_floor;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          count_q <= (klo_q > khi_q) ? '0 : COUNT_W'(khi_q - klo_q + wide_t'(1));
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o           = state_q != S_IDLE;
  assign done_o           = done_q;
  assign solution_count_o = count_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted query did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("count strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("count strobe while still busy");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("query finished without a count");

endmodule

FILE: src/ldrc_div.sv
// -----------------------------------------------------------------------------
// ldrc_div
// Serial signed divider, one quotient bit per cycle, truncating like C.
// -----------------------------------------------------------------------------
module ldrc_div import ldrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  wide_t num_i,
  input  den_t  den_i,
  output logic  busy_o,
  output wide_t quo_o,
  output den_t  rem_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     qmag_q;
  logic [DEN_W-1:0]     rmag_q;
  logic [DEN_W-1:0]     dmag_q;
  logic                 nneg_q;
  logic                 qneg_q;
  wide_t                quo_q;
  den_t                 rem_q;

  logic [DEN_W:0]       shift;
  logic                 fits;
  logic [DEN_W:0]       diff;

  assign shift = {rmag_q, qmag_q[NUM_W-1]};
  assign fits  = shift >= {1'b0, dmag_q};
  assign diff  = shift - {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (!busy_q) begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(NUM_W);
        qmag_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
        dmag_q <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
        rmag_q <= '0;
        nneg_q <= num_i[NUM_W-1];
        qneg_q <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      end
    end else if (cnt_q != '0) begin
      rmag_q <= fits ? diff[DEN_W-1:0] : shift[DEN_W-1:0];
      qmag_q <= {qmag_q[NUM_W-2:0], fits};
      cnt_q  <= cnt_q - 1'b1;
    end else begin
      // apply signs: quotient truncates toward zero, remainder follows dividend
      quo_q  <= qneg_q ? wide_t'(-qmag_q) : wide_t'(qmag_q);
      rem_q  <= nneg_q ? den_t'(-rmag_q) : den_t'(rmag_q);
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
